[hw/rtl/dqvr_pkg.sv]
// Shared opcodes, status codes and field widths for the deque with value removal.
`default_nettype none
package dqvr_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned OUT_W    = 40;

  typedef logic [OP_W-1:0]     opcode_t;
  typedef logic [VAL_W-1:0]    value_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam opcode_t OP_PUSH_FRONT = 3'd0;
  localparam opcode_t OP_PUSH_BACK  = 3'd1;
  localparam opcode_t OP_POP_FRONT  = 3'd2;
  localparam opcode_t OP_POP_BACK   = 3'd3;
  localparam opcode_t OP_REMOVE     = 3'd4;
  localparam opcode_t OP_LIST       = 3'd5;
  localparam opcode_t OP_CLEAR      = 3'd6;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage
`default_nettype wire

[hw/rtl/dqvr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dqvr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/dqvr_ring.sv]
// Ring position unit: (base + offset) modulo DEPTH for in-range operands.
`default_nettype none
module dqvr_ring #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic [$clog2(DEPTH)-1:0] base,
  input  wire logic [$clog2(DEPTH)-1:0] offset,
  output logic      [$clog2(DEPTH)-1:0] pos
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW:0] DEP = (AW+1)'(DEPTH);

  logic [AW:0] sum;
  logic [AW:0] wrapped;

  always_comb begin
    sum     = {1'b0, base} + {1'b0, offset};
    wrapped = (sum >= DEP) ? (sum - DEP) : sum;
    pos     = wrapped[AW-1:0];
  end

endmodule
`default_nettype wire

[hw/rtl/deque_with_value_removal.sv]
// Top level: deque with value removal, sequencer around the ring RAM.
// Deque of signed 32-bit values held in a ring RAM of DEPTH entries.
// Input channel in_*: tuser = opcode (push front/back, pop front/back,
// remove value, list, clear), tdata = operand value. One transaction is
// taken at a time; in_tready stays low until its last result is loaded
// into the output register.
// Output channel out_*: tdata = read value, status, entry count; tlast
// marks the final result of an operation.
// Push, pop, clear and the unused opcode pass through the execute and
// response states and give a single result. Remove walks the RAM once, one
// entry per cycle through the registered read port. List reads each entry
// in an address state, then a data state that waits on the output register.
// Reset (synchronous, rst_n low) empties the deque and zeroes the head; the
// RAM is not cleared and is only read at live entries.
// A stalled receiver holds the output register; the sequencer waits on it
// and no result is dropped.
`default_nettype none
module deque_with_value_removal #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] operand_value
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] read_value, [33:32] status,
                                       // [38:34] entry_count, [39] zero
  output logic             out_tlast
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RESP = 3'd2;
  localparam logic [2:0] S_RM   = 3'd3;
  localparam logic [2:0] S_LR   = 3'd4;
  localparam logic [2:0] S_LW   = 3'd5;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [2:0]             state_r, state_nxt;
  dqvr_pkg::opcode_t      op_r, op_nxt;
  dqvr_pkg::value_t       val_r, val_nxt;
  dqvr_pkg::status_t      status_r, status_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          kept_r, kept_nxt;
  logic                   pend_r, pend_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [39:0]            out_data_r, out_data_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  dqvr_pkg::value_t       wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  dqvr_pkg::value_t       rd_data;

  logic [AW-1:0]          ring_off;
  logic [AW-1:0]          ring_pos;
  logic                   slot_free;
  logic                   is_full;
  logic                   is_empty;
  logic [CW+4:0]          cnt_ext;
  logic [CW-1:0]          idx_inc;

  dqvr_ram #(
    .WIDTH (dqvr_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dqvr_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .base   (head_r),
    .offset (ring_off),
    .pos    (ring_pos)
  );

  assign slot_free = !out_valid_r || out_tready;
  assign is_full   = (count_r == CW'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign cnt_ext   = {5'b0, count_r};
  assign idx_inc   = idx_r + CW'(1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    case (op_r)
      dqvr_pkg::OP_PUSH_FRONT: ring_off = AW'(DEPTH - 1);
      dqvr_pkg::OP_PUSH_BACK:  ring_off = count_r[AW-1:0];
      dqvr_pkg::OP_POP_FRONT:  ring_off = AW'(1);
      default:                 ring_off = '0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    idx_nxt       = idx_r;
    kept_nxt      = kept_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    wr_addr       = ring_pos;
    wr_data       = val_r;
    rd_en         = 1'b0;
    rd_addr       = rd_ptr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          val_nxt   = in_tdata;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt = dqvr_pkg::ST_OK;
        state_nxt  = S_RESP;
        rd_ptr_nxt = head_r;
        wr_ptr_nxt = head_r;
        idx_nxt    = '0;
        kept_nxt   = '0;
        pend_nxt   = 1'b0;
        case (op_r)
          dqvr_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
              status_nxt = dqvr_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              head_nxt  = ring_pos;
              count_nxt = count_r + CW'(1);
            end
          end
          dqvr_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
              status_nxt = dqvr_pkg::ST_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
            end
          end
          dqvr_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
              status_nxt = dqvr_pkg::ST_EMPTY;
            end else begin
              head_nxt  = ring_pos;
              count_nxt = count_r - CW'(1);
            end
          end
          dqvr_pkg::OP_POP_BACK: begin
            if (is_empty) begin
              status_nxt = dqvr_pkg::ST_EMPTY;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
          dqvr_pkg::OP_REMOVE: begin
            if (is_empty) begin
              status_nxt = dqvr_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_RM;
            end
          end
          dqvr_pkg::OP_LIST: begin
            if (is_empty) begin
              status_nxt = dqvr_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_LR;
            end
          end
          dqvr_pkg::OP_CLEAR: begin
            count_nxt = '0;
            head_nxt  = '0;
          end
          default: begin
          end
        endcase
      end
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cnt_ext[4:0], status_r, 32'd0};
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RM: begin
        // read stream at rd_ptr, survivors written back compacted at wr_ptr
        rd_en    = (idx_r != count_r);
        pend_nxt = rd_en;
        if (rd_en) begin
          idx_nxt    = idx_inc;
          rd_ptr_nxt = ptr_inc(rd_ptr_r);
        end
        if (pend_r && (rd_data != val_r)) begin
          wr_en      = 1'b1;
          wr_addr    = wr_ptr_r;
          wr_data    = rd_data;
          wr_ptr_nxt = ptr_inc(wr_ptr_r);
          kept_nxt   = kept_r + CW'(1);
        end
        if (!rd_en && !pend_r) begin
          count_nxt = kept_r;
          state_nxt = S_RESP;
        end
      end
      S_LR: begin
        rd_en     = 1'b1;
        state_nxt = S_LW;
      end
      S_LW: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, cnt_ext[4:0], dqvr_pkg::ST_OK, rd_data};
          out_last_nxt  = (idx_inc == count_r);
          idx_nxt       = idx_inc;
          rd_ptr_nxt    = ptr_inc(rd_ptr_r);
          state_nxt     = (idx_inc == count_r) ? S_IDLE : S_LR;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    idx_r      <= idx_nxt;
    kept_r     <= kept_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire
